### rtl/zcgs_pkg.sv
// ----------------------------------------------------------------------------
// zcgs_pkg
// Shared constants, tables and types of the zero-centered Gaussian sampler:
// the RCDT row table, the Bernoulli threshold table and the result command.
// ----------------------------------------------------------------------------
package zcgs_pkg;

  localparam int TABLE_ROWS      = 46;
  localparam int RCDT_ROWS_DEF   = 46;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_W   = 8;
  localparam int Z_W      = 6;
  localparam int SAMPLE_W = 7;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;

  // last byte of a 12-byte draw, top byte of a 64-bit threshold
  localparam logic [CNT_W-1:0] DRAW_LAST = 4'd11;
  localparam logic [IDX_W-1:0] CMP_TOP   = 3'd7;

  // cumulative table rows, high word first, compared as 96-bit values
  localparam logic [95:0] RCDT_ROW [TABLE_ROWS] = '{
    96'hd2a38e7a_3fff4d84_bc396d43, 96'ha69ac6bf_da7ae854_36d0d36e,
    96'h7e528772_1ec56d67_2213dd0c, 96'h5b98c2b5_8bb65892_1c1d3424,
    96'h3f6302c2_92aec6e1_d2b0d8fb, 96'h29ca7c5c_227d75c3_89072e42,
    96'h1a362826_1d416f8c_fb9c5eec, 96'h0f9ecb75_29bb8425_6f3d1adf,
    96'h08d5cc61_8b87a754_dd49939d, 96'h04bd2950_59f0dc6e_9a387ccb,
    96'h026895ae_d1be6101_dba53116, 96'h0128c0a1_6024e90d_ade813b0,
    96'h00872ba1_c37e6d43_6f4c9258, 96'h003a3e52_da6cf6d1_866f2fe3,
    96'h0017bb11_0106f01b_bb8c70b9, 96'h000923b0_34c570b5_fecbab40,
    96'h00035379_f088e441_2ceba6f8, 96'h000124bc_7681175f_533911f3,
    96'h00005f0d_8efb8f9e_345e028d, 96'h00001d24_dc0cc354_3d6d844e,
    96'h0000086f_a8d3afb2_c4ebb552, 96'h0000024e_18c1ff02_d4ad724c,
    96'h00000098_2c65d88c_fc9fe6f9, 96'h00000025_08266d2a_c7399432,
    96'h00000008_80d08bfd_4d2a65b2, 96'h00000001_d7937718_54414f93,
    96'h00000000_6060068c_01eb5e1a, 96'h00000000_12943cde_f2f53f4b,
    96'h00000000_0360d649_3b0b5d73, 96'h00000000_009450c3_219c4645,
    96'h00000000_0017fce7_83b5fdc1, 96'h00000000_0003a8a0_8204c575,
    96'h00000000_000086b6_47836773, 96'h00000000_00001245_0836b6e9,
    96'h00000000_00000256_1480da58, 96'h00000000_00000048_1c2a537c,
    96'h00000000_00000008_327872e6, 96'h00000000_00000000_e0e5f785,
    96'h00000000_00000000_16b92b61, 96'h00000000_00000000_022a1926,
    96'h00000000_00000000_0031c15b, 96'h00000000_00000000_00043631,
    96'h00000000_00000000_00005607, 96'h00000000_00000000_00000677,
    96'h00000000_00000000_00000074, 96'h00000000_00000000_00000007
  };

  // Bernoulli acceptance thresholds, one per base value
  localparam logic [63:0] THRESH [TABLE_ROWS+1] = '{
    64'hff868492c56944ef, 64'hfe943a8eaf5010ef, 64'hfda2d647a374b2ad,
    64'hfcb256e3cb57c2bb, 64'hfbc2bb8a1f079e2f, 64'hfad40362645c8bf3,
    64'hf9e62d952e359bcf, 64'hf8f9394bdbb63e7b, 64'hf80d25b0978495ff,
    64'hf721f1ee57087dbb, 64'hf6379d30d9ab4973, 64'hf54e26a4a8183a99,
    64'hf4658d77137dab3f, 64'hf37dd0d634ceedf1, 64'hf296eff0ec06e1e7,
    64'hf1b0e9f6df6b3abf, 64'hf0cbbe187ad07b37, 64'hefe76b86eedea22d,
    64'hef03f17430568935, 64'hee214f12f757f42b, 64'hed3f8396bea8511f,
    64'hec5e8e33c2fa27cf, 64'heb7e6e1f0235383f, 64'hea9f228e3abf4793,
    64'he9c0aab7eac59ab1, 64'he8e305d34f871de5, 64'he8063318649f3901,
    64'he72a31bfe3514f3d, 64'he64f010341d4ea3d, 64'he574a01cb2a28f9d,
    64'he49b0e4723c14063, 64'he3c24abe3e14a1b3, 64'he2ea54be64abce17,
    64'he2132b84b410ced9, 64'he13cce4f0198bcb3, 64'he0673c5bdab48751,
    64'hdf9274ea844262db, 64'hdebe773af9dfdb2b, 64'hddeb428ded3c8bd1,
    64'hdd18d624c56d7c73, 64'hdc4731419e4120d9, 64'hdb7653274793fc19,
    64'hdaa63b1944a5e631, 64'hd9d6e85bcb6ff38f, 64'hd9085a33c3fafde5,
    64'hd83a8fe6c7b6cd97, 64'hd76d88bb20d1e361
  };

  // result command from the front to the back
  typedef struct packed {
    logic           neg;  // emit -mag, else mag + 1
    logic [Z_W-1:0] mag;
  } zcgs_cmd_t;

endpackage

### rtl/zcgs_if.sv
// ----------------------------------------------------------------------------
// zcgs_if
// Valid/ready channels of the sampler: random bytes in, samples out.
// ----------------------------------------------------------------------------
interface zcgs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rand_byte;

  modport source (output valid, output rand_byte, input ready);
  modport sink (input valid, input rand_byte, output ready);
endinterface

interface zcgs_sample_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### rtl/zcgs_front.sv
// ----------------------------------------------------------------------------
// zcgs_front
// Takes random bytes, classifies each as entropy, draw or compare byte,
// counts RCDT rows above the draw byte by byte and decides each result.
// ----------------------------------------------------------------------------
module zcgs_front #(
  parameter int RCDT_ROWS = zcgs_pkg::RCDT_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  zcgs_byte_if.sink          in_ch,
  output logic               push_valid,
  output zcgs_pkg::zcgs_cmd_t push_cmd,
  input  logic               push_ready
);
  import zcgs_pkg::*;

  localparam int N = (RCDT_ROWS > TABLE_ROWS) ? TABLE_ROWS : RCDT_ROWS;

  localparam logic [1:0] PH_ENTROPY = 2'd0;
  localparam logic [1:0] PH_GATHER  = 2'd1;
  localparam logic [1:0] PH_COMPARE = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] entropy_r, entropy_nxt;
  logic [IDX_W-1:0]  bitpos_r, bitpos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;
  logic [N-1:0]      lt_r, lt_nxt, lt_step;
  logic [Z_W-1:0]    z0_r, z0_nxt, z0_cnt;
  logic [BYTE_W-1:0] b, thr_byte;
  logic              accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign b           = in_ch.rand_byte;

  // per-row compare, least significant byte first; equal keeps the lower result
  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_step[i] = (b < RCDT_ROW[i][{cnt_r, 3'b000} +: BYTE_W]) ||
                   ((b == RCDT_ROW[i][{cnt_r, 3'b000} +: BYTE_W]) &&
                    (cnt_r != '0) && lt_r[i]);
    end
  end

  // rows that exceed the finished draw
  always_comb begin
    z0_cnt = '0;
    for (int i = 0; i < N; i++) begin
      z0_cnt = z0_cnt + Z_W'(lt_step[i]);
    end
  end

  assign thr_byte = THRESH[z0_r][{cidx_r, 3'b000} +: BYTE_W];

  // byte sequencer
  always_comb begin
    phase_nxt   = phase_r;
    entropy_nxt = entropy_r;
    bitpos_nxt  = bitpos_r;
    cnt_nxt     = cnt_r;
    cidx_nxt    = cidx_r;
    lt_nxt      = lt_r;
    z0_nxt      = z0_r;
    push_valid  = 1'b0;
    push_cmd    = '{neg: 1'b0, mag: z0_r};
    if (accept) begin
      unique case (phase_r)
        PH_GATHER: begin
          lt_nxt = lt_step;
          if (cnt_r != DRAW_LAST) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            cnt_nxt = '0;
            z0_nxt  = z0_cnt;
            if (!entropy_r[bitpos_r]) begin
              push_valid = 1'b1;
              push_cmd   = '{neg: 1'b1, mag: z0_cnt};
              phase_nxt  = PH_ENTROPY;
              bitpos_nxt = '0;
            end else begin
              phase_nxt = PH_COMPARE;
              cidx_nxt  = CMP_TOP;
            end
          end
        end
        PH_COMPARE: begin
          if (b < thr_byte) begin
            push_valid = 1'b1;
            phase_nxt  = PH_ENTROPY;
            bitpos_nxt = '0;
            cidx_nxt   = CMP_TOP;
          end else if (b == thr_byte && cidx_r != '0) begin
            cidx_nxt = cidx_r - 1'b1;
          end else begin
            // reject: next entropy bit, or a new entropy item after the last
            cidx_nxt = CMP_TOP;
            cnt_nxt  = '0;
            if (bitpos_r == '1) begin
              phase_nxt  = PH_ENTROPY;
              bitpos_nxt = '0;
            end else begin
              phase_nxt  = PH_GATHER;
              bitpos_nxt = bitpos_r + 1'b1;
            end
          end
        end
        default: begin
          entropy_nxt = b;
          bitpos_nxt  = '0;
          cnt_nxt     = '0;
          phase_nxt   = PH_GATHER;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ENTROPY;
      bitpos_r <= '0;
      cnt_r    <= '0;
      cidx_r   <= CMP_TOP;
    end else begin
      phase_r  <= phase_nxt;
      bitpos_r <= bitpos_nxt;
      cnt_r    <= cnt_nxt;
      cidx_r   <= cidx_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    entropy_r <= entropy_nxt;
    lt_r      <= lt_nxt;
    z0_r      <= z0_nxt;
  end

endmodule

### rtl/zcgs_queue.sv
// ----------------------------------------------------------------------------
// zcgs_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module zcgs_queue #(
  parameter int DEPTH = zcgs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  zcgs_pkg::zcgs_cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output zcgs_pkg::zcgs_cmd_t pop_cmd,
  input  logic                pop_ready
);
  import zcgs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);

  zcgs_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_Q-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != CNT_Q'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill updates
  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

### rtl/zcgs_back.sv
// ----------------------------------------------------------------------------
// zcgs_back
// Turns a result command into a signed sample and holds it in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module zcgs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  input  zcgs_pkg::zcgs_cmd_t pop_cmd,
  output logic                pop_ready,
  zcgs_sample_if.source       out_ch
);
  import zcgs_pkg::*;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       load;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign load      = pop_valid && pop_ready;

  // sample formatting: negated base or base plus one
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (pop_cmd.neg) begin
        out_sample_nxt = SAMPLE_W'(-{1'b0, pop_cmd.mag});
      end else begin
        out_sample_nxt = SAMPLE_W'({1'b0, pop_cmd.mag} + 1'b1);
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

endmodule

### rtl/zero_center_gaussian_sampler.sv
// ----------------------------------------------------------------------------
// zero_center_gaussian_sampler
// Discrete Gaussian sampler, RCDT base with a byte-wise Bernoulli step.
// ----------------------------------------------------------------------------
// The block takes one random byte per cycle for as long as its command queue
// has room, and the queue only fills when the sink holds off for many cycles,
// since a sample needs at least thirteen bytes (an entropy byte and a 12-byte
// draw). Each byte is compared against all RCDT rows in the cycle it arrives,
// so the base value is ready right after the last draw byte and the Bernoulli
// compare runs on the very next byte. A sample reaches the output by way of a
// queue entry and then the output register, and waits while the sink holds
// off. There is no configuration and no start-up sweep.
// ----------------------------------------------------------------------------
module zero_center_gaussian_sampler #(
  parameter int RCDT_ROWS   = zcgs_pkg::RCDT_ROWS_DEF,
  parameter int QUEUE_DEPTH = zcgs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  zcgs_byte_if.sink     in_ch,
  zcgs_sample_if.source out_ch
);
  import zcgs_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  zcgs_cmd_t push_cmd, pop_cmd;

  // front: byte classification and decisions
  zcgs_front #(
    .RCDT_ROWS (RCDT_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // queue between the two sides
  zcgs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  // back: sample formatting and output register
  zcgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  // the front only decides a result on an accepted item, so the queue has room
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("result pushed into a full queue");

  // two results are never decided in consecutive cycles
  a_push_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> !push_valid)
    else $error("results decided back to back");

  // samples stay within the table range
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.sample >= -7'sd46 && out_ch.sample <= 7'sd47))
    else $error("sample out of range");

endmodule
